// ===== sv/alpwm_pkg.sv =====
// Shared constants and types for the averaged level LED PWM block.
// No dependencies; imported by every module of the block.
package alpwm_pkg;

    localparam int WINDOW_LEN_DEF = 16;
    localparam int PWM_STEPS_DEF  = 100;
    localparam int SAMPLE_W       = 12;
    localparam int SAMPLE_MAX     = 4095;
    localparam int MID_SCALE      = 2048;
    localparam int FULL_LEVEL     = 1000;
    localparam int TOTAL_OUT_W    = 16;
    localparam int DUTY_OUT_W     = 7;
    localparam logic ENABLE_RST   = 1'b1;

    typedef enum logic [1:0] {
        POL_IDLE     = 2'd0,
        POL_POSITIVE = 2'd1,
        POL_NEGATIVE = 2'd2
    } t_polarity;

endpackage

// ===== sv/alpwm_ring.sv =====
// Sample window memory with a registered read and per-entry valid bits.
// Entries never written since reset read as zero. Depends on alpwm_pkg.
module alpwm_ring
    import alpwm_pkg::*;
#(
    parameter int DEPTH  = WINDOW_LEN_DEF,
    parameter int DATA_W = SAMPLE_W,
    localparam int A_W   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [A_W-1:0]    i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [A_W-1:0]    i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? mem[i_rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/averaged_level_led_pwm.sv =====
// Averaged level LED PWM: an eight-stage pipeline that accepts one sample beat per cycle
// while the output is not held, and returns one result beat for each accepted sample.
// The window memory read takes one stage, the running total update the next, and the duty
// division by 1000*WINDOW_LEN is a reciprocal multiply with one correction over four
// stages. The window is cleared at reset through per-entry valid bits, so samples are
// accepted from the first cycle after reset. Stalled stages hold; empty stages fill.
// Depends on alpwm_pkg and alpwm_ring.
module averaged_level_led_pwm
    import alpwm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int PWM_STEPS  = PWM_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] led_positive_on, [1] led_negative_on,
                                        // [3:2] polarity, [10:4] duty_compare,
                                        // [26:11] window_total, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int A_W      = $clog2(WINDOW_LEN);
    localparam int TOT_W    = $clog2(SAMPLE_MAX * WINDOW_LEN + 1);
    localparam int CENTRE   = MID_SCALE * WINDOW_LEN;
    localparam int MAG_W    = $clog2(CENTRE + 1);
    localparam int P_W      = $clog2(PWM_STEPS + 1);
    localparam int CNT_W    = $clog2(PWM_STEPS);
    localparam int X_W      = MAG_W + P_W;
    localparam int DIV      = FULL_LEVEL * WINDOW_LEN;
    localparam int D_W      = $clog2(DIV + 1);
    localparam longint unsigned RECIP = (64'd1 << X_W) / DIV;
    localparam int M_W      = $clog2(RECIP + 1);
    localparam int PROD_W   = X_W + M_W;
    localparam int Q_W      = M_W;
    localparam int QD_W     = Q_W + D_W;
    localparam int DU_W     = (Q_W + 1 > P_W) ? Q_W + 1 : P_W;
    localparam int NSTG     = 8;

    logic              r_enable;
    logic [A_W-1:0]    r_slot;
    logic [TOT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_cnt;
    logic [NSTG:1]     r_vld;
    logic [NSTG:1]     free;
    logic              accept;
    logic              fire1;
    logic [SAMPLE_W-1:0] old_sample;
    logic [TOT_W-1:0]  n_total;
    logic [CNT_W-1:0]  n_cnt;

    logic [SAMPLE_W-1:0] r_s1;
    logic [A_W-1:0]      r_slot1;
    logic [TOT_W-1:0]    r_tot2, r_tot3, r_tot4, r_tot5, r_tot6, r_tot7;
    logic [CNT_W-1:0]    r_cnt2, r_cnt3, r_cnt4, r_cnt5, r_cnt6, r_cnt7;
    logic                r_pos3, r_pos4, r_pos5, r_pos6, r_pos7;
    logic [MAG_W-1:0]    r_mag3;
    logic [X_W-1:0]      r_x4, r_x5, r_x6;
    logic [PROD_W-1:0]   r_prod5;
    logic [Q_W-1:0]      r_q6;
    logic [QD_W-1:0]     r_qd6;
    logic [Q_W:0]        r_q7;
    logic [X_W-1:0]      rem;
    logic [DU_W-1:0]     duty_wide;
    logic [P_W-1:0]      duty;
    logic                lit;

    logic                r_o_led_pos;
    logic                r_o_led_neg;
    t_polarity           r_o_pol;
    logic [DUTY_OUT_W-1:0]  r_o_duty;
    logic [TOTAL_OUT_W-1:0] r_o_total;

    always_comb begin
        free[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            free[k] = !r_vld[k] || free[k + 1];
        end
    end

    assign s_axis_tready = free[1];
    assign accept        = s_axis_tvalid && free[1];
    assign fire1         = r_vld[1] && free[2];
    assign o_cfg_ready   = 1'b1;

    alpwm_ring #(
        .DEPTH  (WINDOW_LEN),
        .DATA_W (SAMPLE_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_slot),
        .o_rd_data (old_sample),
        .i_wr_en   (fire1),
        .i_wr_addr (r_slot1),
        .i_wr_data (r_s1)
    );

    assign n_total = r_total - TOT_W'(old_sample) + TOT_W'(r_s1);
    assign n_cnt   = (r_cnt == CNT_W'(PWM_STEPS - 1)) ? '0 : r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= ENABLE_RST;
            r_slot   <= '0;
            r_total  <= '0;
            r_cnt    <= '0;
            r_vld    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            if (accept) begin
                r_slot <= (r_slot == A_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
            end
            if (fire1) begin
                r_total <= n_total;
                r_cnt   <= n_cnt;
            end
            if (free[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (free[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free[1]) begin
            r_s1    <= s_axis_tdata[SAMPLE_W-1:0];
            r_slot1 <= r_slot;
        end
        if (free[2]) begin
            r_tot2 <= n_total;
            r_cnt2 <= n_cnt;
        end
        if (free[3]) begin
            r_tot3 <= r_tot2;
            r_cnt3 <= r_cnt2;
            r_pos3 <= r_tot2 > TOT_W'(CENTRE);
            r_mag3 <= (r_tot2 > TOT_W'(CENTRE)) ? MAG_W'(r_tot2 - TOT_W'(CENTRE))
                                                 : MAG_W'(TOT_W'(CENTRE) - r_tot2);
        end
        if (free[4]) begin
            r_tot4 <= r_tot3;
            r_cnt4 <= r_cnt3;
            r_pos4 <= r_pos3;
            r_x4   <= X_W'(r_mag3) * X_W'(PWM_STEPS);
        end
        if (free[5]) begin
            r_tot5  <= r_tot4;
            r_cnt5  <= r_cnt4;
            r_pos5  <= r_pos4;
            r_x5    <= r_x4;
            r_prod5 <= PROD_W'(r_x4) * PROD_W'(RECIP);
        end
        if (free[6]) begin
            r_tot6 <= r_tot5;
            r_cnt6 <= r_cnt5;
            r_pos6 <= r_pos5;
            r_x6   <= r_x5;
            r_q6   <= r_prod5[PROD_W-1:X_W];
            r_qd6  <= QD_W'(r_prod5[PROD_W-1:X_W]) * QD_W'(DIV);
        end
        if (free[7]) begin
            r_tot7 <= r_tot6;
            r_cnt7 <= r_cnt6;
            r_pos7 <= r_pos6;
            r_q7   <= (rem >= X_W'(DIV)) ? (Q_W + 1)'(r_q6) + 1'b1 : (Q_W + 1)'(r_q6);
        end
    end

    assign rem       = r_x6 - X_W'(r_qd6);
    assign duty_wide = (DU_W'(r_q7) > DU_W'(PWM_STEPS)) ? DU_W'(PWM_STEPS) : DU_W'(r_q7);
    assign duty      = P_W'(duty_wide);
    assign lit       = P_W'(r_cnt7) < duty;

    always_ff @(posedge i_clk) begin
        if (free[NSTG]) begin
            r_o_total <= TOTAL_OUT_W'(r_tot7);
            if (r_enable) begin
                r_o_duty    <= DUTY_OUT_W'(duty);
                r_o_pol     <= r_pos7 ? POL_POSITIVE : POL_NEGATIVE;
                r_o_led_pos <= r_pos7 && lit;
                r_o_led_neg <= !r_pos7 && lit;
            end else begin
                r_o_duty    <= '0;
                r_o_pol     <= POL_IDLE;
                r_o_led_pos <= 1'b0;
                r_o_led_neg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = {5'd0, r_o_total, r_o_duty, r_o_pol, r_o_led_neg, r_o_led_pos};

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for averaged_level_led_pwm: a directed stimulus table and then
// random sample streams, each output beat checked against a typed row's result or an
// in-bench window/PWM predictor. Depends on alpwm_pkg and the RTL of the block.
module tb
    import alpwm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ROWS    = 26;
    localparam int PHASE_ITEMS = 220;
    localparam int NUM_PHASES  = 5;
    localparam int IDLE_LIMIT  = 2000;
    localparam int CENTRE      = MID_SCALE * WINDOW_LEN_DEF;

    typedef struct packed {
        logic [15:0] total;
        logic [6:0]  duty;
        t_polarity   pol;
        logic        neg;
        logic        pos;
    } t_led_result;

    typedef struct packed {
        logic [11:0] smp;
        logic        en;
        logic        typed;
        t_led_result res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    logic [11:0]  win_store [WINDOW_LEN_DEF];
    int unsigned  win_total;
    int unsigned  win_slot;
    int unsigned  pwm_count;
    logic         led_enable;
    t_led_result  led_expect_q [$];
    int           err_count;
    int           mismatch_count;
    int           results_seen;
    int           items_sent;
    int           idle_cycles;
    bit           sender_gaps;

    t_stim_row stim_table [DIR_ROWS] = '{
        '{12'd0,    1'b1, 1'b1, '{16'd0,     7'd100, POL_NEGATIVE, 1'b1, 1'b0}},
        '{12'd4095, 1'b1, 1'b1, '{16'd4095,  7'd100, POL_NEGATIVE, 1'b1, 1'b0}},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b0, '0},
        '{12'd4095, 1'b1, 1'b1, '{16'd65520, 7'd100, POL_POSITIVE, 1'b0, 1'b1}},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd0,    1'b1, 1'b0, '0},
        '{12'd8,    1'b1, 1'b1, '{16'd32768, 7'd0,   POL_NEGATIVE, 1'b0, 1'b0}},
        '{12'd4095, 1'b0, 1'b1, '{16'd32768, 7'd0,   POL_IDLE,     1'b0, 1'b0}}
    };

    averaged_level_led_pwm u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_led_result predict_led(input logic [11:0] smp);
        int unsigned mag;
        int unsigned duty;
        bit          positive;
        t_led_result r;
        win_total = win_total - win_store[win_slot] + smp;
        win_store[win_slot] = smp;
        win_slot = (win_slot == WINDOW_LEN_DEF - 1) ? 0 : win_slot + 1;
        pwm_count = (pwm_count + 1 >= PWM_STEPS_DEF) ? 0 : pwm_count + 1;
        r = '0;
        r.total = win_total[15:0];
        if (led_enable) begin
            positive = win_total > CENTRE;
            mag = positive ? win_total - CENTRE : CENTRE - win_total;
            duty = mag * PWM_STEPS_DEF / (FULL_LEVEL * WINDOW_LEN_DEF);
            if (duty > PWM_STEPS_DEF) begin
                duty = PWM_STEPS_DEF;
            end
            r.duty = duty[6:0];
            if (positive) begin
                r.pol = POL_POSITIVE;
                r.pos = pwm_count < duty;
            end else begin
                r.pol = POL_NEGATIVE;
                r.neg = pwm_count < duty;
            end
        end else begin
            r.pol = POL_IDLE;
        end
        return r;
    endfunction

    // Entered and left at a falling edge; tvalid stays high between back-to-back beats.
    task automatic send_sample(input logic [11:0] smp, input bit typed, input t_led_result res);
        t_led_result exp_res;
        while (sender_gaps && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_res = predict_led(smp);
        led_expect_q.push_back(typed ? res : exp_res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (led_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_enable(input logic val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        led_enable = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, with one long hold-off to back the pipeline up and one clean run.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= 350) begin
                m_axis_tready <= 1'b0;
                hold_left = 79;
                hold_done = 1'b1;
            end else if (results_seen >= 490 && results_seen < 690) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge i_clk) begin
        t_led_result got;
        t_led_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got = t_led_result'(m_axis_tdata[26:0]);
            if (led_expect_q.size() == 0) begin
                err_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected output beat %h", m_axis_tdata);
                end
            end else begin
                want = led_expect_q.pop_front();
                if (got.pos !== want.pos || got.neg !== want.neg || got.pol !== want.pol
                        || got.duty !== want.duty || got.total !== want.total) begin
                    err_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("beat %0d: exp pos %b neg %b pol %0d duty %0d total %0d",
                                 results_seen, want.pos, want.neg, want.pol, want.duty,
                                 want.total);
                        $display("         got pos %b neg %b pol %0d duty %0d total %0d",
                                 got.pos, got.neg, got.pol, got.duty, got.total);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          mode;
        int          seg_left;
        int          base;
        int          val;
        logic [11:0] smp;
        logic        phase_en [NUM_PHASES];
        phase_en = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        err_count      = 0;
        mismatch_count = 0;
        results_seen   = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        sender_gaps    = 1'b1;
        foreach (win_store[i]) begin
            win_store[i] = '0;
        end
        win_total  = 0;
        win_slot   = 0;
        pwm_count  = 0;
        led_enable = ENABLE_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (stim_table[r].en != led_enable) begin
                set_enable(stim_table[r].en);
            end
            send_sample(stim_table[r].smp, stim_table[r].typed, stim_table[r].res);
        end

        seg_left = 0;
        mode = 0;
        base = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_enable(phase_en[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sender_gaps = !(items_sent >= 500 && items_sent < 680);
                if (seg_left == 0) begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 40);
                    base = $urandom_range(0, SAMPLE_MAX);
                end
                seg_left--;
                case (mode)
                    0: val = $urandom_range(0, SAMPLE_MAX);
                    1: val = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
                    default: begin
                        val = base + $urandom_range(0, 64) - 32;
                        if (val < 0) begin
                            val = 0;
                        end else if (val > SAMPLE_MAX) begin
                            val = SAMPLE_MAX;
                        end
                    end
                endcase
                smp = val[11:0];
                send_sample(smp, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/alpwm_pkg.sv
sv/alpwm_ring.sv
sv/averaged_level_led_pwm.sv
sim/tb.sv
